>>> hdl/pose_error_cost_assert.svh
// assertion macros for the pose error cost block
`ifndef POSE_ERROR_COST_ASSERT_SVH
`define POSE_ERROR_COST_ASSERT_SVH
`ifndef SYNTH
`define PEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose_error_cost: same-cycle check failed");
`define PEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose_error_cost: next-cycle check failed");
`else
`define PEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/pec_pkg.sv
// types, constants and tables shared by the pose error cost block
package pec_pkg;

    localparam int REM_W   = 70;
    localparam int ROOT_W  = 34;
    localparam int SQRT_N  = 34;
    localparam int ABC_W   = 44;
    localparam int CX_W    = 48;
    localparam int Z_W     = 21;
    localparam int CORDIC_N = 17;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SCORE = 2'd2;

    localparam logic CFG_TW = 1'b0;
    localparam logic CFG_OW = 1'b1;

    localparam logic signed [Z_W-1:0] PI_Q   = 21'sd205887;
    localparam logic signed [Z_W-1:0] FOLD_Q = 21'sd205888;
    localparam logic signed [31:0] SENTINEL_Q = -32'sd262144;

    typedef struct packed {
        logic                     valid;
        logic                     sentinel;
        logic                     fixed;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [CX_W-1:0]   cx;
        logic signed [CX_W-1:0]   cy;
        logic signed [Z_W-1:0]    cz;
    } solve_t;

    // arctangent of 2^-i in q16.16 radians
    function automatic logic signed [Z_W-1:0] atan_q(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0: v = 21'sd51472;
            1: v = 21'sd30385;
            2: v = 21'sd16055;
            3: v = 21'sd8150;
            4: v = 21'sd4091;
            5: v = 21'sd2047;
            6: v = 21'sd1024;
            7: v = 21'sd512;
            8: v = 21'sd256;
            9: v = 21'sd128;
            10: v = 21'sd64;
            11: v = 21'sd32;
            12: v = 21'sd16;
            13: v = 21'sd8;
            14: v = 21'sd4;
            15: v = 21'sd2;
            16: v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/pec_solve.sv
// pipelined square root and cordic atan2 with yaw fold, one step per stage
module pec_solve
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  pec_pkg::solve_t in_st,
    output pec_pkg::solve_t out_st
);

    pec_pkg::solve_t st_reg [1:pec_pkg::SQRT_N];

    genvar g;
    generate
        for (g = 0; g < pec_pkg::SQRT_N; g++)
        begin : g_stage
            localparam int B = pec_pkg::SQRT_N - 1 - g;
            pec_pkg::solve_t src;
            pec_pkg::solve_t st_next;
            logic [pec_pkg::REM_W-1:0] trial;
            logic signed [pec_pkg::Z_W-1:0] fv;

            if (g == 0)
            begin : g_first
                assign src = in_st;
            end
            else
            begin : g_rest
                assign src = st_reg[g];
            end

            // one root bit, one rotation, fold after the last rotation
            always_comb
            begin
                st_next = src;
                trial = (pec_pkg::REM_W'(src.root) << (B + 1))
                      | (pec_pkg::REM_W'(1) << (2 * B));
                fv = src.cz + pec_pkg::FOLD_Q;
                if (src.rem >= trial)
                begin
                    st_next.rem  = src.rem - trial;
                    st_next.root = src.root | (pec_pkg::ROOT_W'(1) << B);
                end
                if (g < pec_pkg::CORDIC_N && !src.fixed)
                begin
                    if (src.cy > 0)
                    begin
                        st_next.cx = src.cx + (src.cy >>> g);
                        st_next.cy = src.cy - (src.cx >>> g);
                        st_next.cz = src.cz + pec_pkg::atan_q(g);
                    end
                    else
                    begin
                        st_next.cx = src.cx - (src.cy >>> g);
                        st_next.cy = src.cy + (src.cx >>> g);
                        st_next.cz = src.cz - pec_pkg::atan_q(g);
                    end
                end
                if (g == pec_pkg::CORDIC_N)
                begin
                    if (fv >= (pec_pkg::FOLD_Q <<< 1))
                    begin
                        st_next.cz = fv - (pec_pkg::FOLD_Q <<< 1);
                    end
                    else if (fv >= pec_pkg::FOLD_Q)
                    begin
                        st_next.cz = fv - pec_pkg::FOLD_Q;
                    end
                    else if (fv <= -pec_pkg::FOLD_Q)
                    begin
                        st_next.cz = fv + pec_pkg::FOLD_Q;
                    end
                    else
                    begin
                        st_next.cz = fv;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    st_reg[g+1] <= '0;
                end
                else if (adv)
                begin
                    st_reg[g+1] <= st_next;
                end
            end
        end
    endgenerate

    assign out_st = st_reg[pec_pkg::SQRT_N];

endmodule

>>> hdl/pose_error_cost.sv
// pose error cost: 40 register stages from the edge that accepts an input word
// to the first edge at which its result word can be accepted
// throughput one word per cycle, set by a fully pipelined root and cordic
// chain (one root bit per stage, one rotation per cordic stage); stalls
// freeze all stages; asynchronous active-low reset clears valid bits and
// the reference valid flag, weights reset to 0.5
module pose_error_cost
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic               enough_points,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] score,
    output logic               is_sentinel,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    logic adv;
    logic accept;

    logic [15:0] tw_reg, ow_reg;
    logic signed [31:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic signed [15:0] ref_q_reg [0:3];
    logic ref_valid_reg;

    logic signed [15:0] q_in [0:3];

    // stage 1
    logic s1_valid_reg, s1_sent_reg;
    logic [32:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [31:0] s1_p_reg [0:3][0:3];
    logic signed [32:0] dx_s, dy_s, dz_s;

    // stage 2
    logic s2_valid_reg, s2_sent_reg;
    logic [65:0] s2_dx2_reg, s2_dy2_reg, s2_dz2_reg;
    logic signed [19:0] s2_rw_reg, s2_rx_reg, s2_ry_reg, s2_rz_reg;
    logic signed [33:0] sum_w, sum_x, sum_y, sum_z;

    // stage 3
    logic s3_valid_reg, s3_sent_reg;
    logic [pec_pkg::REM_W-1:0] s3_sq_reg;
    logic signed [39:0] s3_ww_reg, s3_xx_reg, s3_yy_reg, s3_zz_reg;
    logic signed [39:0] s3_xy_reg, s3_wz_reg, s3_xz_reg, s3_wy_reg;

    // stage 4
    logic s4_valid_reg, s4_sent_reg;
    logic [pec_pkg::REM_W-1:0] s4_sq_reg;
    logic signed [pec_pkg::ABC_W-1:0] s4_a_reg, s4_b_reg, s4_c_reg, s4_n_reg;

    pec_pkg::solve_t entry, solved;
    logic signed [pec_pkg::ABC_W-1:0] c_abs;

    // multiply stage
    logic m_valid_reg, m_sent_reg;
    logic [49:0] m_pt_reg;
    logic signed [37:0] m_po_reg;

    logic signed [51:0] s_sum, s_rnd;

    logic out_valid_reg, out_sent_reg;
    logic signed [31:0] out_score_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign q_in[0] = quat_x;
    assign q_in[1] = quat_y;
    assign q_in[2] = quat_z;
    assign q_in[3] = quat_w;

    // weight registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= 16'd128;
            ow_reg <= 16'd128;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pec_pkg::CFG_TW: tw_reg <= cfg_data;
                pec_pkg::CFG_OW: ow_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // reference pose, updated by load and clear words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_valid_reg <= 1'b0;
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                ref_q_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (op == pec_pkg::OP_LOAD)
            begin
                ref_valid_reg <= 1'b1;
                ref_x_reg <= pos_x;
                ref_y_reg <= pos_y;
                ref_z_reg <= pos_z;
                for (int i = 0; i < 4; i++)
                begin
                    ref_q_reg[i] <= q_in[i];
                end
            end
            else if (op == pec_pkg::OP_CLEAR)
            begin
                ref_valid_reg <= 1'b0;
            end
        end
    end

    // stage 1: position differences and quaternion partial products
    always_comb
    begin
        dx_s = 33'(pos_x) - 33'(ref_x_reg);
        dy_s = 33'(pos_y) - 33'(ref_y_reg);
        dz_s = 33'(pos_z) - 33'(ref_z_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept && (op == pec_pkg::OP_SCORE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sent_reg <= !ref_valid_reg || !enough_points;
            s1_dx_reg <= dx_s[32] ? 33'(-dx_s) : 33'(dx_s);
            s1_dy_reg <= dy_s[32] ? 33'(-dy_s) : 33'(dy_s);
            s1_dz_reg <= dz_s[32] ? 33'(-dz_s) : 33'(dz_s);
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    s1_p_reg[i][j] <= q_in[i] * ref_q_reg[j];
                end
            end
        end
    end

    // stage 2: squares and rounded relative quaternion
    always_comb
    begin
        sum_w = 34'(s1_p_reg[3][3]) + 34'(s1_p_reg[0][0])
              + 34'(s1_p_reg[1][1]) + 34'(s1_p_reg[2][2]);
        sum_x = 34'(s1_p_reg[3][0]) - 34'(s1_p_reg[0][3])
              - 34'(s1_p_reg[1][2]) + 34'(s1_p_reg[2][1]);
        sum_y = 34'(s1_p_reg[3][1]) + 34'(s1_p_reg[0][2])
              - 34'(s1_p_reg[1][3]) - 34'(s1_p_reg[2][0]);
        sum_z = 34'(s1_p_reg[3][2]) - 34'(s1_p_reg[0][1])
              + 34'(s1_p_reg[1][0]) - 34'(s1_p_reg[2][3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sent_reg <= s1_sent_reg;
            s2_dx2_reg <= 66'(s1_dx_reg) * 66'(s1_dx_reg);
            s2_dy2_reg <= 66'(s1_dy_reg) * 66'(s1_dy_reg);
            s2_dz2_reg <= 66'(s1_dz_reg) * 66'(s1_dz_reg);
            s2_rw_reg <= 20'((sum_w + 34'sd8192) >>> 14);
            s2_rx_reg <= 20'((sum_x + 34'sd8192) >>> 14);
            s2_ry_reg <= 20'((sum_y + 34'sd8192) >>> 14);
            s2_rz_reg <= 20'((sum_z + 34'sd8192) >>> 14);
        end
    end

    // stage 3: sum of squares and quaternion component products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_sent_reg <= s2_sent_reg;
            s3_sq_reg <= pec_pkg::REM_W'(s2_dx2_reg) + pec_pkg::REM_W'(s2_dy2_reg)
                       + pec_pkg::REM_W'(s2_dz2_reg);
            s3_ww_reg <= s2_rw_reg * s2_rw_reg;
            s3_xx_reg <= s2_rx_reg * s2_rx_reg;
            s3_yy_reg <= s2_ry_reg * s2_ry_reg;
            s3_zz_reg <= s2_rz_reg * s2_rz_reg;
            s3_xy_reg <= s2_rx_reg * s2_ry_reg;
            s3_wz_reg <= s2_rw_reg * s2_rz_reg;
            s3_xz_reg <= s2_rx_reg * s2_rz_reg;
            s3_wy_reg <= s2_rw_reg * s2_ry_reg;
        end
    end

    // stage 4: rotation matrix terms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_sent_reg <= s3_sent_reg;
            s4_sq_reg <= s3_sq_reg;
            s4_a_reg <= pec_pkg::ABC_W'(s3_ww_reg) + pec_pkg::ABC_W'(s3_xx_reg)
                      - pec_pkg::ABC_W'(s3_yy_reg) - pec_pkg::ABC_W'(s3_zz_reg);
            s4_b_reg <= (pec_pkg::ABC_W'(s3_xy_reg) + pec_pkg::ABC_W'(s3_wz_reg)) <<< 1;
            s4_c_reg <= (pec_pkg::ABC_W'(s3_xz_reg) - pec_pkg::ABC_W'(s3_wy_reg)) <<< 1;
            s4_n_reg <= pec_pkg::ABC_W'(s3_ww_reg) + pec_pkg::ABC_W'(s3_xx_reg)
                      + pec_pkg::ABC_W'(s3_yy_reg) + pec_pkg::ABC_W'(s3_zz_reg);
        end
    end

    // solver entry: gimbal lock, zero sine term and half-plane pre-rotation
    always_comb
    begin
        c_abs = s4_c_reg[pec_pkg::ABC_W-1] ? -s4_c_reg : s4_c_reg;
        entry = '0;
        entry.valid = s4_valid_reg;
        entry.sentinel = s4_sent_reg;
        entry.rem = s4_sq_reg;
        entry.root = '0;
        entry.cx = pec_pkg::CX_W'(s4_a_reg);
        entry.cy = pec_pkg::CX_W'(s4_b_reg);
        entry.cz = '0;
        entry.fixed = 1'b0;
        if (c_abs >= s4_n_reg)
        begin
            entry.fixed = 1'b1;
        end
        else if (s4_b_reg == '0)
        begin
            entry.fixed = 1'b1;
            entry.cz = (s4_a_reg < 0) ? pec_pkg::PI_Q : '0;
        end
        else if (s4_a_reg < 0)
        begin
            entry.cx = -pec_pkg::CX_W'(s4_a_reg);
            entry.cy = -pec_pkg::CX_W'(s4_b_reg);
            entry.cz = (s4_b_reg > 0) ? pec_pkg::PI_Q : -pec_pkg::PI_Q;
        end
    end

    pec_solve u_solve
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_st  (entry),
        .out_st (solved)
    );

    // weight multiplies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= solved.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_sent_reg <= solved.sentinel;
            m_pt_reg <= 50'(tw_reg) * 50'(solved.root);
            m_po_reg <= $signed({1'b0, ow_reg}) * solved.cz;
        end
    end

    // final sum, rounding and saturation
    always_comb
    begin
        s_sum = $signed({2'b00, m_pt_reg}) + 52'(m_po_reg);
        s_rnd = (s_sum + 52'sd128) >>> 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_sent_reg <= m_sent_reg;
            if (m_sent_reg)
            begin
                out_score_reg <= pec_pkg::SENTINEL_Q;
            end
            else if (s_rnd > 52'sd2147483647)
            begin
                out_score_reg <= 32'sh7FFFFFFF;
            end
            else if (s_rnd < -52'sd2147483648)
            begin
                out_score_reg <= 32'sh80000000;
            end
            else
            begin
                out_score_reg <= 32'(s_rnd);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign score       = out_score_reg;
    assign is_sentinel = out_sent_reg;

`include "pose_error_cost_assert.svh"

    `PEC_ASSERT_IMP(a_sent_score, clk, rst_n, out_valid && is_sentinel, score == pec_pkg::SENTINEL_Q)
    `PEC_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(score))
    `PEC_ASSERT_NXT(a_clear, clk, rst_n, accept && op == pec_pkg::OP_CLEAR, !ref_valid_reg)
    `PEC_ASSERT_NXT(a_load, clk, rst_n, accept && op == pec_pkg::OP_LOAD, ref_valid_reg)

endmodule

>>> tb/pose_error_cost_chk.sv
// checker for the pose error cost block: predicts each score word and compares
`timescale 1ns / 100ps

module pose_error_cost_chk
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic               enough_points,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] score,
    input  logic               is_sentinel,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 checked_count,
    output int                 sentinel_count
);

    typedef struct {
        logic signed [31:0] score;
        logic               sentinel;
    } cost_t;

    cost_t              cost_q[$];
    logic [15:0]        w_trans;
    logic [15:0]        w_orient;
    logic signed [31:0] goal_pos[3];
    logic signed [15:0] goal_quat[4];
    logic               goal_valid;

    assign pending = cost_q.size();

    // floor square root of a sum of squares
    function automatic logic [33:0] floor_root(input logic [69:0] v);
        logic [69:0] r;
        logic [69:0] c;
        r = '0;
        for (int i = 33; i >= 0; i--)
        begin
            c = r | (70'd1 << i);
            if (c * c <= v)
                r = c;
        end
        return r[33:0];
    endfunction

    // vectoring cordic arctangent in q16.16 radians
    function automatic longint yaw_of(input longint y_in, input longint x_in);
        longint x, y, z, nx, ny;
        x = x_in;
        y = y_in;
        z = 0;
        if (y == 0)
            return (x < 0) ? longint'(pec_pkg::PI_Q) : 0;
        if (x < 0)
        begin
            z = (y > 0) ? longint'(pec_pkg::PI_Q) : -longint'(pec_pkg::PI_Q);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < pec_pkg::CORDIC_N; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + longint'(pec_pkg::atan_q(i));
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - longint'(pec_pkg::atan_q(i));
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint round14(input longint v);
        return (v + 8192) >>> 14;
    endfunction

    // weighted cost of one end pose against the goal
    function automatic cost_t pose_cost(input logic signed [31:0] px, py, pz,
                                        input logic signed [15:0] qx, qy, qz, qw,
                                        input logic enough);
        cost_t       res;
        longint      d;
        logic [69:0] ad[3];
        logic [69:0] sq;
        logic [33:0] root_len;
        longint      ax, ay, az, aw, bx, by, bz, bw, rx, ry, rz, rw;
        longint      a, b, c, n, yaw, fy, s;
        if (!goal_valid || !enough)
        begin
            res.score    = pec_pkg::SENTINEL_Q;
            res.sentinel = 1'b1;
            return res;
        end
        d = longint'(px) - longint'(goal_pos[0]);
        ad[0] = 70'((d < 0) ? -d : d);
        d = longint'(py) - longint'(goal_pos[1]);
        ad[1] = 70'((d < 0) ? -d : d);
        d = longint'(pz) - longint'(goal_pos[2]);
        ad[2] = 70'((d < 0) ? -d : d);
        sq = ad[0] * ad[0] + ad[1] * ad[1] + ad[2] * ad[2];
        root_len = floor_root(sq);
        // relative rotation conj(end) * goal
        ax = -longint'(qx);
        ay = -longint'(qy);
        az = -longint'(qz);
        aw = qw;
        bx = goal_quat[0];
        by = goal_quat[1];
        bz = goal_quat[2];
        bw = goal_quat[3];
        rw = round14(aw * bw - ax * bx - ay * by - az * bz);
        rx = round14(aw * bx + ax * bw + ay * bz - az * by);
        ry = round14(aw * by - ax * bz + ay * bw + az * bx);
        rz = round14(aw * bz + ax * by - ay * bx + az * bw);
        a = rw * rw + rx * rx - ry * ry - rz * rz;
        b = 2 * (rx * ry + rw * rz);
        c = 2 * (rx * rz - rw * ry);
        n = rw * rw + rx * rx + ry * ry + rz * rz;
        // gimbal lock gives zero yaw
        if (((c < 0) ? -c : c) >= n)
            yaw = 0;
        else
            yaw = yaw_of(b, a);
        fy = (yaw + longint'(pec_pkg::FOLD_Q)) % longint'(pec_pkg::FOLD_Q);
        s = longint'(w_trans) * longint'(root_len) + longint'(w_orient) * fy;
        s = (s + 128) >>> 8;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        res.score    = s[31:0];
        res.sentinel = 1'b0;
        return res;
    endfunction

    // track config, predict on accepted input words, compare result words
    always @(posedge clk or negedge rst_n)
    begin
        cost_t want;
        if (!rst_n)
        begin
            cost_q.delete();
            w_trans        <= 16'd128;
            w_orient       <= 16'd128;
            goal_pos[0]    <= '0;
            goal_pos[1]    <= '0;
            goal_pos[2]    <= '0;
            goal_quat[0]   <= '0;
            goal_quat[1]   <= '0;
            goal_quat[2]   <= '0;
            goal_quat[3]   <= '0;
            goal_valid     <= 1'b0;
            fail_count     <= 0;
            checked_count  <= 0;
            sentinel_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == pec_pkg::CFG_TW)
                    w_trans <= cfg_data;
                else
                    w_orient <= cfg_data;
            end
            if (in_valid && in_ready)
            begin
                case (op)
                    pec_pkg::OP_LOAD:
                    begin
                        goal_pos[0]  <= pos_x;
                        goal_pos[1]  <= pos_y;
                        goal_pos[2]  <= pos_z;
                        goal_quat[0] <= quat_x;
                        goal_quat[1] <= quat_y;
                        goal_quat[2] <= quat_z;
                        goal_quat[3] <= quat_w;
                        goal_valid   <= 1'b1;
                    end
                    pec_pkg::OP_CLEAR:
                        goal_valid <= 1'b0;
                    pec_pkg::OP_SCORE:
                        cost_q.push_back(pose_cost(pos_x, pos_y, pos_z, quat_x, quat_y,
                                                   quat_z, quat_w, enough_points));
                    default:
                        ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (cost_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result word with nothing expected: score %0d sentinel %0b",
                                 score, is_sentinel);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = cost_q.pop_front();
                    checked_count <= checked_count + 1;
                    if (want.sentinel)
                        sentinel_count <= sentinel_count + 1;
                    if (score !== want.score || is_sentinel !== want.sentinel)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: score exp %0d got %0d, sentinel exp %0b got %0b",
                                     want.score, score, want.sentinel, is_sentinel);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/pose_error_cost_tb.sv
// testbench top for the pose error cost block: stimulus, config phases and verdict
`timescale 1ns / 100ps

module pose_error_cost_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 60;
    localparam int RAND_WORDS  = 800;

    // op code with no meaning, the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               enough_points;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] score;
    logic               is_sentinel;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [15:0]        cfg_data;

    int fail_count;
    int pending;
    int checked_count;
    int sentinel_count;
    int cycles = 0;
    int stall_left;
    logic gaps_on;
    logic stalls_on;

    pose_error_cost uut (.*);

    pose_error_cost_chk chk (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stall after each result word while stalls are on
    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else if (out_valid && out_ready)
        begin
            w = stalls_on ? $urandom_range(0, 13) : 0;
            stall_left <= w;
            out_ready  <= (w == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // send one input word, idling first for a random gap when gaps are on
    task automatic send_word(input logic [1:0] o, input logic signed [31:0] x, y, z,
                             input logic signed [15:0] qx, qy, qz, qw,
                             input logic enough);
        int gap;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op            <= o;
        pos_x         <= x;
        pos_y         <= y;
        pos_z         <= z;
        quat_x        <= qx;
        quat_y        <= qy;
        quat_z        <= qz;
        quat_w        <= qw;
        enough_points <= enough;
        in_valid      <= 1'b1;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    // wait until all results are back and the pipe is quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // one register write, then cfg_valid is dropped again and the bench idles
    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_quat();
        if ($urandom_range(0, 19) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1 << 22) - (1 << 21);
            default: return $urandom_range(0, 1 << 18) - (1 << 17);
        endcase
    endfunction

    // one random word, mostly scoring against a loaded goal
    task automatic random_word();
        int k;
        logic [1:0] o;
        k = $urandom_range(0, 99);
        if (k < 8)
            o = pec_pkg::OP_LOAD;
        else if (k < 11)
            o = pec_pkg::OP_CLEAR;
        else if (k < 13)
            o = OP_UNUSED;
        else
            o = pec_pkg::OP_SCORE;
        send_word(o, rand_pos(), rand_pos(), rand_pos(), rand_quat(), rand_quat(),
                  rand_quat(), rand_quat(), ($urandom_range(0, 15) != 0));
    endtask

    initial
    begin
        logic [15:0] tw_set[5];
        logic [15:0] ow_set[5];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = pec_pkg::OP_LOAD;
        pos_x         = '0;
        pos_y         = '0;
        pos_z         = '0;
        quat_x        = '0;
        quat_y        = '0;
        quat_z        = '0;
        quat_w        = '0;
        enough_points = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = pec_pkg::CFG_TW;
        cfg_data      = '0;
        gaps_on       = 1'b0;
        stalls_on     = 1'b0;
        tw_set = '{16'd128, 16'd0, 16'hFFFF, 16'd256, 16'd0};
        ow_set = '{16'd128, 16'hFFFF, 16'd0, 16'd77, 16'hFFFF};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no goal, then goal cases and the special yaw paths
        send_word(pec_pkg::OP_SCORE, 0, 0, 0, 0, 0, 0, 16384, 1'b1);
        send_word(pec_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, 16384, 1'b0);
        send_word(pec_pkg::OP_SCORE, 0, 0, 0, 0, 0, 0, 16384, 1'b1);
        send_word(pec_pkg::OP_SCORE, 0, 0, 0, 0, 0, 0, 16384, 1'b0);
        send_word(pec_pkg::OP_SCORE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                  0, 0, 0, 16384, 1'b1);
        send_word(pec_pkg::OP_SCORE, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  16384, 0, 0, 0, 1'b1);
        send_word(pec_pkg::OP_SCORE, 65536, -65536, 3, 0, 11585, 0, 11585, 1'b1);
        send_word(pec_pkg::OP_SCORE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_word(pec_pkg::OP_SCORE, 5, 5, 5, 0, 0, 11585, 11585, 1'b1);
        send_word(pec_pkg::OP_SCORE, 5, 5, 5, 0, 0, -11585, 11585, 1'b1);
        send_word(pec_pkg::OP_SCORE, 7, 7, 7, -16384, -16384, -16384, -16384, 1'b1);
        send_word(OP_UNUSED, 1, 2, 3, 4, 5, 6, 7, 1'b1);
        send_word(pec_pkg::OP_LOAD, 32'sh80000000, 32'sh7FFFFFFF, -1, 16384, 16384,
                  16384, 16384, 1'b1);
        send_word(pec_pkg::OP_SCORE, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 16384, 1'b1);
        send_word(pec_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_word(pec_pkg::OP_SCORE, 1, 1, 1, 0, 0, 0, 16384, 1'b1);
        send_word(pec_pkg::OP_LOAD, -100, 200, -300, 0, 0, 0, 16384, 1'b1);
        send_word(pec_pkg::OP_SCORE, 100, -200, 300, 0, 0, 16384, 0, 1'b1);

        // random phases through several weight settings
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_reg(pec_pkg::CFG_TW, tw_set[ph]);
            write_reg(pec_pkg::CFG_OW, ow_set[ph]);
            gaps_on   = (ph != 2);
            stalls_on = (ph != 3);
            send_word(pec_pkg::OP_LOAD, rand_pos(), rand_pos(), rand_pos(), rand_quat(),
                      rand_quat(), rand_quat(), rand_quat(), 1'b1);
            for (int i = 0; i < RAND_WORDS / 5; i++)
            begin
                random_word();
                if (ph == 1 && i == 80)
                    drain();
            end
        end

        drain();
        $display("covered %0d score words (%0d sentinel) over 5 weight settings",
                 checked_count, sentinel_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/pec_pkg.sv
hdl/pec_solve.sv
hdl/pose_error_cost.sv
tb/pose_error_cost_chk.sv
tb/pose_error_cost_tb.sv
